// File: rtl/bfl_pkg.sv
// Shared types and constants of the block id free-list allocator.
// Depends on nothing; used by bfl_store, the top level and the checker.
`default_nettype none

package bfl_pkg;

  localparam int unsigned ID_W  = 12;  // block id width
  localparam int unsigned CNT_W = 13;  // free, total and used counts
  localparam int unsigned LEN_W = 16;  // block length register
  localparam int unsigned OFS_W = 28;  // byte offset
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 2;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RESET = 16'd512;

  typedef enum logic [OP_W-1:0] {
    OP_FREE   = 3'd0,
    OP_TAKE   = 3'd1,
    OP_NEW    = 3'd2,
    OP_COMMIT = 3'd3,
    OP_LOCATE = 3'd4
  } bfl_op_e;

  typedef enum logic [ST_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_RANGE     = 2'd2,
    STATUS_EMPTY     = 2'd3
  } bfl_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } bfl_state_e;

  // Strobes from the sequencer to the memories
  typedef struct packed {
    logic ring_re;
    logic ring_we;
    logic map_re;
    logic map_we;
    logic map_wbit;
  } bfl_mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bfl_store.sv
// Free ring and is-free bitmap of the allocator, both synchronous memories
// with registered reads. Depends on bfl_pkg.
`default_nettype none

module bfl_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire                       clk_i,
  input  wire  bfl_pkg::bfl_mem_ctl_t ctl_i,
  input  wire  [AW-1:0]             ring_raddr_i,
  input  wire  [AW-1:0]             ring_waddr_i,
  input  wire  [bfl_pkg::ID_W-1:0]  ring_wdata_i,
  output logic [bfl_pkg::ID_W-1:0]  ring_rdata_o,
  input  wire  [AW-1:0]             map_raddr_i,
  input  wire  [AW-1:0]             map_waddr_i,
  output logic                      map_rdata_o
);
  import bfl_pkg::*;

  logic [ID_W-1:0] ring_mem [DEPTH];
  logic            map_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ring_we) begin
      ring_mem[ring_waddr_i] <= ring_wdata_i;
    end
    if (ctl_i.ring_re) begin
      ring_rdata_o <= ring_mem[ring_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.map_we) begin
      map_mem[map_waddr_i] <= ctl_i.map_wbit;
    end
    if (ctl_i.map_re) begin
      map_rdata_o <= map_mem[map_raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/block_id_free_list_allocator.sv
// A request is accepted in IDLE and executed in EXEC, where its result is
// registered at the output once the output register is free.
// A new request is taken only after EXEC is left, as the free ring and
// bitmap are read when a request is accepted and written back in EXEC.
// A result waiting at the output holds the write-back cycle until it is taken.
// Reset clears the counts and the ring head and loads block_length with 512.
// Memories are not swept: a bitmap entry is cleared when its block is committed.
`default_nettype none

module block_id_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [bfl_pkg::LEN_W-1:0]          cfg_wdata_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [11:0] block_id, [15:12] zero
  input  wire  [bfl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [2:0] op
  input  wire  [bfl_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [1:0] status, [14:2] result_id, [42:15] byte_offset, [55:43] free_count,
  // [68:56] total_count, [81:69] used_count, [87:82] zero
  output logic [bfl_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import bfl_pkg::*;

  // Ids are 12 bits wide, so no more than 4096 blocks can ever exist
  localparam int unsigned DEPTH = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0]       DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [AW-1:0]     LAST_A  = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CAP     = CNT_W'(DEPTH);

  bfl_state_e          state_q, state_d;
  logic [LEN_W-1:0]    blen_q;
  logic [OP_W-1:0]     op_q;
  logic [ID_W-1:0]     id_q;
  logic [AW-1:0]       head_q, head_d;
  logic [CNT_W-1:0]    size_q, size_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  bfl_mem_ctl_t        mem_ctl;
  logic [ID_W-1:0]     ring_rdata;
  logic                map_rdata;
  logic [AW-1:0]       ring_waddr;
  logic [AW-1:0]       map_waddr;

  logic                accept;
  logic                go;
  logic [CNT_W-1:0]    id_ext;
  logic [AW:0]         tail_sum;
  logic [AW-1:0]       tail;
  logic [AW-1:0]       head_inc;
  bfl_status_e         status;
  logic [CNT_W-1:0]    result_id;
  logic                ofs_ok;
  logic [OFS_W-1:0]    offset;
  logic [CNT_W-1:0]    used;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign go            = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign id_ext   = {1'b0, id_q};
  assign tail_sum = {1'b0, head_q} + size_q[AW:0];
  assign tail     = (tail_sum >= DEPTH_A) ? AW'(tail_sum - DEPTH_A) : tail_sum[AW-1:0];
  assign head_inc = (head_q == LAST_A) ? '0 : head_q + 1'b1;
  assign offset   = ofs_ok ? OFS_W'(OFS_W'(id_q) * OFS_W'(blen_q)) : '0;
  assign used     = total_d - size_d;

  bfl_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .ring_raddr_i (head_q),
    .ring_waddr_i (ring_waddr),
    .ring_wdata_i (id_q),
    .ring_rdata_o (ring_rdata),
    .map_raddr_i  (s_axis_tdata[AW-1:0]),
    .map_waddr_i  (map_waddr),
    .map_rdata_o  (map_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      blen_q    <= BLOCK_LENGTH_RESET;
      head_q    <= '0;
      size_q    <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      size_q    <= size_d;
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        blen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= s_axis_tuser;
      id_q <= s_axis_tdata[ID_W-1:0];
    end
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    size_d     = size_q;
    total_d    = total_q;
    status     = STATUS_OK;
    result_id  = '0;
    ofs_ok     = 1'b0;
    mem_ctl    = '0;
    ring_waddr = tail;
    map_waddr  = id_q[AW-1:0];

    // Issue the reads with the request; the data is there in EXEC
    mem_ctl.ring_re = accept;
    mem_ctl.map_re  = accept;

    case (op_q)
      OP_FREE: begin
        if ((id_ext < total_q) && map_rdata) begin
          status = STATUS_DUPLICATE;
        end else if ((id_ext >= total_q) || (size_q >= CAP)) begin
          status = STATUS_RANGE;
        end else begin
          mem_ctl.ring_we  = go;
          mem_ctl.map_we   = go;
          mem_ctl.map_wbit = 1'b1;
          size_d           = size_q + 1'b1;
        end
      end
      OP_TAKE: begin
        if (size_q == '0) begin
          status = STATUS_EMPTY;
        end else begin
          result_id        = {1'b0, ring_rdata};
          map_waddr        = ring_rdata[AW-1:0];
          mem_ctl.map_we   = go;
          mem_ctl.map_wbit = 1'b0;
          head_d           = head_inc;
          size_d           = size_q - 1'b1;
        end
      end
      OP_NEW: begin
        result_id = total_q;
      end
      OP_COMMIT: begin
        if (id_ext > total_q) begin
          status = STATUS_RANGE;
        end else if (id_ext == total_q) begin
          if (total_q >= CAP) begin
            status = STATUS_RANGE;
          end else begin
            // A block entering the file starts out not free
            mem_ctl.map_we   = go;
            mem_ctl.map_wbit = 1'b0;
            total_d          = total_q + 1'b1;
            ofs_ok           = 1'b1;
          end
        end else begin
          ofs_ok = 1'b1;
        end
      end
      OP_LOCATE: begin
        if (id_ext < total_q) begin
          ofs_ok = 1'b1;
        end else begin
          status = STATUS_RANGE;
        end
      end
      default: begin
      end
    endcase

    // Hold everything while the previous result waits
    if (!go) begin
      head_d  = head_q;
      size_d  = size_q;
      total_d = total_q;
    end

    if (accept) begin
      state_d = ST_EXEC;
    end else if (go) begin
      state_d = ST_IDLE;
    end

    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (go) begin
      m_valid_d = 1'b1;
      m_data_d  = {6'b0, used, total_d, size_d, offset, result_id, status};
    end
  end

endmodule

`default_nettype wire

// File: rtl/bfl_checker.sv
// Port-level checks of the allocator's result stream and request pacing,
// bound to block_id_free_list_allocator. Depends on bfl_pkg.
`default_nettype none

module bfl_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tvalid,
  input wire                                s_axis_tready,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [bfl_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import bfl_pkg::*;

  logic [ST_W-1:0]  r_status;
  logic [CNT_W-1:0] r_rid;
  logic [CNT_W-1:0] r_free;
  logic [CNT_W-1:0] r_total;
  logic [CNT_W-1:0] r_used;

  assign r_status = m_axis_tdata[1:0];
  assign r_rid    = m_axis_tdata[14:2];
  assign r_free   = m_axis_tdata[55:43];
  assign r_total  = m_axis_tdata[68:56];
  assign r_used   = m_axis_tdata[81:69];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> r_used == CNT_W'(r_total - r_free))
    else $error("used count is not total minus free");

  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> r_free <= r_total)
    else $error("free count exceeds total");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (r_status == STATUS_EMPTY) |-> (r_free == '0) && (r_rid == '0))
    else $error("empty status with listed ids");

  a_pace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken in the cycle after another");

endmodule

bind block_id_free_list_allocator bfl_checker u_bfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
